/* rtl/lpct_pkg.sv */
// Shared types and constants of the page cache tag controller.
`default_nettype none
package lpct_pkg;

   localparam int PAGE_NUM_W   = 32;
   localparam int PAGE_BYTES_W = 15;
   localparam int SLOT_FIELD_W = 6;
   localparam int OFFSET_W     = 20;
   localparam int FLASH_ADDR_W = 46;
   localparam int PROD_W       = PAGE_NUM_W + PAGE_BYTES_W;

   typedef logic [PAGE_NUM_W-1:0]   page_num_type;
   typedef logic [PAGE_BYTES_W-1:0] page_bytes_type;
   typedef logic [SLOT_FIELD_W-1:0] slot_field_type;
   typedef logic [OFFSET_W-1:0]     offset_type;
   typedef logic [FLASH_ADDR_W-1:0] flash_addr_type;
   typedef logic [PROD_W-1:0]       prod_type;

   localparam page_bytes_type PAGE_BYTES_RESET = 15'd2048;

endpackage
`default_nettype wire

/* rtl/lpct_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lpct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/lpct_mul.sv */
// Shared registered multiplier that scales page and slot numbers by the page size.
`default_nettype none
module lpct_mul (
   input  wire logic                    clock,
   input  wire lpct_pkg::page_num_type  a,
   input  wire lpct_pkg::page_bytes_type b,
   output lpct_pkg::prod_type           prod
);
   import lpct_pkg::*;

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(a) * PROD_W'(b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

/* rtl/lru_page_cache_tags.sv */
// Top level of the fully associative page cache tag and LRU replacement controller.
`default_nettype none
// Each request item carries a flash page number. The block walks the recency list from
// the most recent entry down, reading one recency entry and one tag per cycle through
// a small three-stage pipeline around a single tag comparator, and shifts the list down
// by one behind the walk so that the slot found ends up at the front. A hit returns the
// slot; a miss takes the next free slot (slots are never released, so this is always the
// slot numbered by the fill count) or, when all SLOTS slots are in use, reclaims the
// least recent slot and reports its old page. One shared multiplier then forms the flash
// byte address and the buffer offset from the page size register. A hit at list position
// p scans p + 1 recency entries, a miss scans all occupied entries, and a miss on an
// empty cache skips the walk. The block is ready again in the cycle the result appears.
// The speed of the walk is set by the one-entry-per-cycle read ports of the recency and
// tag memories. The block takes one item at a time, but it accepts the next item while
// the previous result still waits in the output register; a result that is still waiting
// when the next one is ready holds the block in its last step until the output register
// frees. No memory needs clearing after reset: the fill count marks which entries are
// valid. The page size register is written through the csr channel, which is always
// ready, and should only be written while the block is idle.
module lru_page_cache_tags #(
   parameter int SLOTS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire lpct_pkg::page_num_type    req_page_number,
   // Result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output lpct_pkg::slot_field_type       rsp_slot,
   output logic                           rsp_hit,
   output logic                           rsp_fill_needed,
   output lpct_pkg::offset_type           rsp_buffer_offset,
   output lpct_pkg::flash_addr_type       rsp_flash_address,
   output logic                           rsp_evicted,
   output lpct_pkg::page_num_type         rsp_evicted_page,
   // Configuration channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire lpct_pkg::page_bytes_type  csr_page_bytes
);
   import lpct_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_FINAL  = 3'd2;
   localparam logic [2:0] ST_MUL_A  = 3'd3;
   localparam logic [2:0] ST_MUL_B  = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] used_count_ff, used_count_in;
   logic [CNT_W-1:0] iss_idx_ff, iss_idx_in;
   logic             b_vld_ff, b_vld_in;
   logic             c_vld_ff, c_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   page_bytes_type   page_bytes_ff, page_bytes_in;

   // Payload state.
   logic [SLOT_W-1:0] b_idx_ff, b_idx_in;
   logic [SLOT_W-1:0] c_idx_ff, c_idx_in;
   logic [SLOT_W-1:0] c_slot_ff, c_slot_in;
   logic [SLOT_W-1:0] last_slot_ff, last_slot_in;
   page_num_type      last_tag_ff, last_tag_in;
   page_num_type      page_ff, page_in;
   logic [SLOT_W-1:0] s_ff, s_in;
   logic              hit_ff, hit_in;
   logic              evict_ff, evict_in;
   page_num_type      evict_page_ff, evict_page_in;
   flash_addr_type    flash_ff, flash_in;

   slot_field_type    rsp_slot_ff, rsp_slot_in;
   logic              rsp_hit_ff, rsp_hit_in;
   offset_type        rsp_offset_ff, rsp_offset_in;
   flash_addr_type    rsp_flash_ff, rsp_flash_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   page_num_type      rsp_evict_page_ff, rsp_evict_page_in;

   // Memory ports.
   logic              rec_wr_en;
   logic [SLOT_W-1:0] rec_wr_addr;
   logic [SLOT_W-1:0] rec_wr_data;
   logic [SLOT_W-1:0] rec_rd_addr;
   logic [SLOT_W-1:0] rec_rd_data;
   logic              tag_wr_en;
   page_num_type      tag_rd_data;

   // Shared multiplier.
   page_num_type      mul_a;
   prod_type          mul_prod;

   logic              list_full;
   logic              tag_match;
   logic              out_free;

   lpct_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_recency (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   lpct_ram #(
      .WIDTH (PAGE_NUM_W),
      .DEPTH (SLOTS)
   ) u_tags (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (s_in),
      .wr_data (page_ff),
      .rd_addr (rec_rd_data),
      .rd_data (tag_rd_data)
   );

   lpct_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (page_bytes_ff),
      .prod  (mul_prod)
   );

   assign list_full = (used_count_ff == CNT_W'(SLOTS));
   assign tag_match = (tag_rd_data == page_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in          = state_ff;
      used_count_in     = used_count_ff;
      iss_idx_in        = iss_idx_ff;
      b_vld_in          = 1'b0;
      c_vld_in          = 1'b0;
      b_idx_in          = b_idx_ff;
      c_idx_in          = b_idx_ff;
      c_slot_in         = rec_rd_data;
      last_slot_in      = last_slot_ff;
      last_tag_in       = last_tag_ff;
      page_in           = page_ff;
      s_in              = s_ff;
      hit_in            = hit_ff;
      evict_in          = evict_ff;
      evict_page_in     = evict_page_ff;
      flash_in          = flash_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_offset_in     = rsp_offset_ff;
      rsp_flash_in      = rsp_flash_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      rsp_evict_page_in = rsp_evict_page_ff;
      page_bytes_in     = page_bytes_ff;
      rec_wr_en         = 1'b0;
      rec_wr_addr       = '0;
      rec_wr_data       = c_slot_ff;
      rec_rd_addr       = iss_idx_ff[SLOT_W-1:0];
      tag_wr_en         = 1'b0;
      mul_a             = page_ff;

      if (csr_valid) begin
         page_bytes_in = csr_page_bytes;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in       = req_page_number;
               iss_idx_in    = '0;
               hit_in        = 1'b0;
               evict_in      = 1'b0;
               evict_page_in = '0;
               if (used_count_ff == '0) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            // Issue stage: read the next recency entry while the list lasts.
            if (iss_idx_ff < used_count_ff) begin
               b_vld_in   = 1'b1;
               b_idx_in   = iss_idx_ff[SLOT_W-1:0];
               iss_idx_in = iss_idx_ff + CNT_W'(1);
            end
            // Second stage: the tag read is addressed by the recency data directly.
            c_vld_in = b_vld_ff;
            // Compare stage.
            if (c_vld_ff) begin
               if (tag_match) begin
                  hit_in   = 1'b1;
                  s_in     = c_slot_ff;
                  b_vld_in = 1'b0;
                  c_vld_in = 1'b0;
                  state_in = ST_FINAL;
               end else begin
                  // Shift this entry one place toward the least recent end.
                  if (c_idx_ff != SLOT_W'(SLOTS - 1)) begin
                     rec_wr_en   = 1'b1;
                     rec_wr_addr = c_idx_ff + SLOT_W'(1);
                  end
                  last_slot_in = c_slot_ff;
                  last_tag_in  = tag_rd_data;
                  if ((CNT_W'(c_idx_ff) + CNT_W'(1)) == used_count_ff) begin
                     b_vld_in = 1'b0;
                     c_vld_in = 1'b0;
                     state_in = ST_FINAL;
                  end
               end
            end
         end

         ST_FINAL: begin
            if (!hit_ff) begin
               tag_wr_en = 1'b1;
               if (list_full) begin
                  s_in          = last_slot_ff;
                  evict_in      = 1'b1;
                  evict_page_in = last_tag_ff;
               end else begin
                  s_in          = used_count_ff[SLOT_W-1:0];
                  used_count_in = used_count_ff + CNT_W'(1);
               end
            end
            // The chosen slot becomes the most recent entry.
            rec_wr_en   = 1'b1;
            rec_wr_addr = '0;
            rec_wr_data = s_in;
            state_in    = ST_MUL_A;
         end

         ST_MUL_A: begin
            mul_a    = page_ff;
            state_in = ST_MUL_B;
         end

         ST_MUL_B: begin
            flash_in = mul_prod[FLASH_ADDR_W-1:0];
            mul_a    = PAGE_NUM_W'(s_ff);
            state_in = ST_OUT;
         end

         ST_OUT: begin
            mul_a = PAGE_NUM_W'(s_ff);
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_slot_in       = SLOT_FIELD_W'(s_ff);
               rsp_hit_in        = hit_ff;
               rsp_offset_in     = mul_prod[OFFSET_W-1:0];
               rsp_flash_in      = flash_ff;
               rsp_evicted_in    = evict_ff;
               rsp_evict_page_in = evict_page_ff;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_count_ff <= '0;
         iss_idx_ff    <= '0;
         b_vld_ff      <= 1'b0;
         c_vld_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         page_bytes_ff <= PAGE_BYTES_RESET;
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         iss_idx_ff    <= iss_idx_in;
         b_vld_ff      <= b_vld_in;
         c_vld_ff      <= c_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         page_bytes_ff <= page_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      b_idx_ff          <= b_idx_in;
      c_idx_ff          <= c_idx_in;
      c_slot_ff         <= c_slot_in;
      last_slot_ff      <= last_slot_in;
      last_tag_ff       <= last_tag_in;
      page_ff           <= page_in;
      s_ff              <= s_in;
      hit_ff            <= hit_in;
      evict_ff          <= evict_in;
      evict_page_ff     <= evict_page_in;
      flash_ff          <= flash_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_offset_ff     <= rsp_offset_in;
      rsp_flash_ff      <= rsp_flash_in;
      rsp_evicted_ff    <= rsp_evicted_in;
      rsp_evict_page_ff <= rsp_evict_page_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_fill_needed   = !rsp_hit_ff;
   assign rsp_buffer_offset = rsp_offset_ff;
   assign rsp_flash_address = rsp_flash_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_evicted_page  = rsp_evict_page_ff;

endmodule
`default_nettype wire
